// ===== rtl/buddy_block_allocator_unit_defines.svh =====
// assertion macros for the buddy allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(label, clk, rst_n, prop, msg)
`define BBA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/bba_pkg.sv =====
package bba_pkg;
  localparam int unsigned GranOrder = 6;
  localparam int unsigned AddrW     = 17;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgW      = 5;
  localparam int unsigned OrdW      = 5;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNull     = 3'd1;
  localparam logic [StatusW-1:0] StNoBlock  = 3'd2;
  localparam logic [StatusW-1:0] StNotOwner = 3'd3;
  localparam logic [StatusW-1:0] StNotReady = 3'd4;

  typedef struct packed {
    logic                  kind;
    logic [SizeW-1:0]      request_size;
    logic [AddrW-1:0]      address;
  } bba_req_t;

  typedef struct packed {
    logic [AddrW-1:0]   address_res;
    logic [StatusW-1:0] status;
  } bba_res_t;
endpackage

// ===== rtl/bba_req_if.sv =====
interface bba_req_if;
  import bba_pkg::*;
  logic     valid;
  logic     ready;
  bba_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bba_res_if.sv =====
interface bba_res_if;
  import bba_pkg::*;
  logic     valid;
  logic     ready;
  bba_res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bba_link_mem.sv =====
// one granule-indexed memory, one write and one registered read per cycle
module bba_link_mem #(
  parameter int unsigned DEPTH_W = 10,
  parameter int unsigned DATA_W  = 11
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [DEPTH_W-1:0] waddr_i,
  input  logic [DATA_W-1:0]  wdata_i,
  input  logic [DEPTH_W-1:0] raddr_i,
  output logic [DATA_W-1:0]  rdata_o
);
  logic [DATA_W-1:0] mem_q [2**DEPTH_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/buddy_block_allocator_unit.sv =====
// buddy block allocator
// requests arrive on req (kind, request_size, address); each gives exactly one
// result on res (address_res, status). the block takes one request at a time:
// ready is low from acceptance until the result has been taken.
// a sequencer drives the order/index logic and the write port and registered
// read port of each granule memory (order, next, prev, free tag).
// a zero size, a null or not-ready request and an out-of-range or misaligned
// free go straight to the result; a free that fails the tag or order check
// ends after the granule read. an allocate scans up from the needed order,
// pops a block and splits it once per order down to the needed one; the first
// allocate sets up the pool first; a failed allocate scans past MAX_ORDER.
// a free merges with its free buddy one level at a time until a buddy check
// fails or the block reaches the pool order, then pushes it.
// after reset the free tags are cleared one granule per cycle, and req.ready
// rises once all 2**(MAX_ORDER-6) granules (1024 by default) are clear; the
// pool is not ready and all lists are empty until the first allocate with a
// nonzero size. pool_order writes are ignored once the pool is ready. a result
// waits in the output register while res.ready is low.
module buddy_block_allocator_unit #(
  parameter int unsigned MAX_ORDER    = 16,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [bba_pkg::CfgW-1:0] cfg_wdata_i,
  bba_req_if.sink               req,
  bba_res_if.source             res
);
  import bba_pkg::*;
  `include "buddy_block_allocator_unit_defines.svh"

  localparam int unsigned GW    = MAX_ORDER - GranOrder;      // granule index width
  localparam int unsigned NGRAN = 2 ** GW;
  localparam int unsigned LW    = GW + 1;                      // link width incl. null
  localparam int unsigned NLIST = MAX_ORDER + 1;
  localparam logic [LW-1:0] Nil = LW'(NGRAN);
  localparam int unsigned NW    = 40;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADEC, S_SCAN, S_POPRD, S_POPWR, S_SPLIT, S_SPLIT2, S_AFIN,
    S_FCHK, S_FRD, S_FVAL, S_BRD, S_BCHK, S_UNRD, S_UNLNK, S_UNLNK2,
    S_PUSH, S_PUSH2, S_DONE
  } state_e;

  state_e               state_q;
  logic                 ready_q, rvalid_q, pool_ready_q, resume_q;
  logic [CfgW-1:0]      pool_order_q;
  logic [LW-1:0]        head_q [NLIST];
  logic [GW-1:0]        clr_q;
  logic [SizeW-1:0]     size_q;
  logic [AddrW-1:0]     addr_q;
  logic [OrdW-1:0]      k_q, o_q, pord_q;
  logic [GW-1:0]        g_q, b_q;
  logic [LW-1:0]        n_q, p_q;
  logic [AddrW-1:0]     res_addr_q;
  logic [StatusW-1:0]   res_st_q;

  // memory ports
  logic            om_we, nm_we, pm_we, tm_we;
  logic [GW-1:0]   om_wa, nm_wa, pm_wa, tm_wa, om_ra, nm_ra, pm_ra;
  logic [OrdW-1:0] om_wd, om_rd;
  logic [LW-1:0]   nm_wd, pm_wd, nm_rd, pm_rd;
  logic            tm_wd, tm_rd;

  bba_link_mem #(.DEPTH_W(GW), .DATA_W(OrdW)) u_ord (
    .clk_i, .we_i(om_we), .waddr_i(om_wa), .wdata_i(om_wd), .raddr_i(om_ra),
    .rdata_o(om_rd));
  bba_link_mem #(.DEPTH_W(GW), .DATA_W(LW)) u_next (
    .clk_i, .we_i(nm_we), .waddr_i(nm_wa), .wdata_i(nm_wd), .raddr_i(nm_ra),
    .rdata_o(nm_rd));
  bba_link_mem #(.DEPTH_W(GW), .DATA_W(LW)) u_prev (
    .clk_i, .we_i(pm_we), .waddr_i(pm_wa), .wdata_i(pm_wd), .raddr_i(pm_ra),
    .rdata_o(pm_rd));
  // free tags share the order memory's read address
  bba_link_mem #(.DEPTH_W(GW), .DATA_W(1)) u_tag (
    .clk_i, .we_i(tm_we), .waddr_i(tm_wa), .wdata_i(tm_wd), .raddr_i(om_ra),
    .rdata_o(tm_rd));

  // effective pool order
  logic [OrdW-1:0] eff;
  always_comb begin
    if (pool_order_q < CfgW'(GranOrder)) eff = OrdW'(GranOrder);
    else if (pool_order_q > CfgW'(MAX_ORDER)) eff = OrdW'(MAX_ORDER);
    else eff = pool_order_q;
  end

  // helper logic: granule step for an order, and needed order from size
  function automatic logic [GW-1:0] gstep(input logic [OrdW-1:0] o);
    logic [OrdW-1:0] d;
    d = o - OrdW'(GranOrder);
    return GW'(1) << d;
  endfunction

  logic [NW-1:0]   need;
  logic [OrdW-1:0] kneed;
  always_comb begin
    need  = NW'(size_q) + NW'(HEADER_BYTES) - NW'(1);
    kneed = OrdW'(GranOrder);
    for (int i = GranOrder; i < 18; i++) begin
      if (need[i]) kneed = OrdW'(i + 1);
    end
  end

  logic [OrdW-1:0] lidx;
  assign lidx = (o_q > OrdW'(MAX_ORDER)) ? OrdW'(MAX_ORDER) : o_q;

  logic [NW-1:0] t_full;
  assign t_full = NW'(addr_q) - NW'(HEADER_BYTES);

  logic nvalid, pvalid;
  assign nvalid = !n_q[LW-1] && n_q != Nil;
  assign pvalid = !p_q[LW-1] && p_q != Nil;

  logic rd_nil;
  assign rd_nil = nm_rd[LW-1];

  always_comb begin
    om_we = 1'b0; om_wa = g_q; om_wd = o_q; om_ra = g_q;
    nm_we = 1'b0; nm_wa = g_q; nm_wd = Nil; nm_ra = g_q;
    pm_we = 1'b0; pm_wa = g_q; pm_wd = Nil; pm_ra = g_q;
    tm_we = 1'b0; tm_wa = g_q; tm_wd = 1'b0;
    case (state_q)
      S_CLR: begin tm_we = 1'b1; tm_wa = clr_q; tm_wd = 1'b0; end
      S_POPRD: begin nm_ra = head_q[o_q][GW-1:0]; end
      S_POPWR: begin
        pm_we = nvalid; pm_wa = n_q[GW-1:0]; pm_wd = Nil;
        nm_we = 1'b1; nm_wa = g_q; nm_wd = Nil;
        tm_we = 1'b1; tm_wa = g_q; tm_wd = 1'b0;
      end
      S_SPLIT: begin
        // push upper half b_q at order o_q
        om_we = 1'b1; om_wa = b_q; om_wd = o_q;
        nm_we = 1'b1; nm_wa = b_q; nm_wd = head_q[lidx];
        pm_we = 1'b1; pm_wa = b_q; pm_wd = Nil;
        tm_we = 1'b1; tm_wa = b_q; tm_wd = 1'b1;
      end
      S_SPLIT2: begin
        pm_we = !head_q[lidx][LW-1]; pm_wa = head_q[lidx][GW-1:0];
        pm_wd = LW'(b_q);
      end
      S_AFIN: begin om_we = 1'b1; om_wa = g_q; om_wd = k_q; end
      S_FRD:  begin om_ra = g_q; end
      S_BRD:  begin om_ra = b_q; end
      S_UNRD: begin nm_ra = b_q; pm_ra = b_q; end
      S_UNLNK: begin
        nm_we = pvalid; nm_wa = p_q[GW-1:0]; nm_wd = n_q;
        pm_we = nvalid; pm_wa = n_q[GW-1:0]; pm_wd = p_q;
      end
      S_UNLNK2: begin
        nm_we = 1'b1; nm_wa = b_q; nm_wd = Nil;
        pm_we = 1'b1; pm_wa = b_q; pm_wd = Nil;
        tm_we = 1'b1; tm_wa = b_q; tm_wd = 1'b0;
      end
      S_PUSH: begin
        om_we = 1'b1; om_wa = g_q; om_wd = o_q;
        nm_we = 1'b1; nm_wa = g_q; nm_wd = head_q[lidx];
        pm_we = 1'b1; pm_wa = g_q; pm_wd = Nil;
        tm_we = 1'b1; tm_wa = g_q; tm_wd = 1'b1;
      end
      S_PUSH2: begin
        pm_we = !head_q[lidx][LW-1]; pm_wa = head_q[lidx][GW-1:0];
        pm_wd = LW'(g_q);
      end
      default: ;
    endcase
  end

  assign req.ready       = ready_q;
  assign res.valid       = rvalid_q;
  assign res.payload.address_res = res_addr_q;
  assign res.payload.status      = res_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_q        <= '0;
      ready_q      <= 1'b0;
      rvalid_q     <= 1'b0;
      pool_ready_q <= 1'b0;
      resume_q     <= 1'b0;
      pool_order_q <= CfgW'(16);
      for (int i = 0; i < NLIST; i++) head_q[i] <= Nil;
    end else begin
      if (cfg_we_i && !pool_ready_q) pool_order_q <= cfg_wdata_i;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + GW'(1);
          if (clr_q == '1) begin
            ready_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid && ready_q) begin
            ready_q    <= 1'b0;
            size_q     <= req.payload.request_size;
            addr_q     <= req.payload.address;
            res_addr_q <= '0;
            res_st_q   <= StOk;
            state_q    <= (req.payload.kind == KindAlloc) ? S_ADEC : S_FCHK;
          end
        end
        S_ADEC: begin
          if (size_q == '0) begin
            res_st_q <= StNull; state_q <= S_DONE;
          end else if (!pool_ready_q) begin
            // whole pool becomes one free block at granule 0, then the scan runs
            pool_ready_q <= 1'b1;
            resume_q     <= 1'b1;
            k_q     <= kneed;
            g_q     <= '0;
            o_q     <= eff;
            state_q <= S_PUSH;
          end else begin
            k_q     <= kneed;
            o_q     <= kneed;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (o_q > OrdW'(MAX_ORDER)) begin
            res_st_q <= StNoBlock; state_q <= S_DONE;
          end else if (!head_q[o_q][LW-1]) begin
            g_q <= head_q[o_q][GW-1:0]; state_q <= S_POPRD;
          end else begin
            o_q <= o_q + OrdW'(1);
          end
        end
        S_POPRD: begin
          n_q     <= '1;
          state_q <= S_POPWR;
        end
        S_POPWR: begin
          // while n_q holds its marker this takes the read next link, then completes the pop
          if (n_q == '1) begin
            n_q <= rd_nil ? Nil : nm_rd;
          end else begin
            head_q[o_q] <= n_q;
            if (o_q > k_q) begin
              o_q     <= o_q - OrdW'(1);
              b_q     <= (g_q + gstep(o_q - OrdW'(1)));
              state_q <= S_SPLIT;
            end else begin
              state_q <= S_AFIN;
            end
          end
        end
        S_SPLIT: state_q <= S_SPLIT2;
        S_SPLIT2: begin
          head_q[lidx] <= LW'(b_q);
          if (o_q > k_q) begin
            o_q <= o_q - OrdW'(1);
            b_q <= (g_q + gstep(o_q - OrdW'(1)));
            state_q <= S_SPLIT;
          end else begin
            state_q <= S_AFIN;
          end
        end
        S_AFIN: begin
          res_addr_q <= AddrW'((NW'(g_q) << GranOrder) + NW'(HEADER_BYTES));
          res_st_q   <= StOk;
          state_q    <= S_DONE;
        end
        S_FCHK: begin
          if (addr_q == '0) begin
            res_st_q <= StNull; state_q <= S_DONE;
          end else if (!pool_ready_q) begin
            res_st_q <= StNotReady; state_q <= S_DONE;
          end else if (NW'(addr_q) < NW'(HEADER_BYTES) ||
                       (t_full >> eff) != '0 ||
                       t_full[GranOrder-1:0] != '0) begin
            res_st_q <= StNotOwner; state_q <= S_DONE;
          end else begin
            g_q     <= GW'(t_full >> GranOrder);
            state_q <= S_FRD;
          end
        end
        S_FRD: state_q <= S_FVAL;
        S_FVAL: begin
          if (tm_rd || om_rd < OrdW'(GranOrder) || om_rd > eff ||
              (g_q & (gstep(om_rd) - GW'(1))) != '0) begin
            res_st_q <= StNotOwner; state_q <= S_DONE;
          end else begin
            o_q <= om_rd;
            b_q <= g_q ^ gstep(om_rd);
            state_q <= (om_rd < eff) ? S_BRD : S_PUSH;
          end
        end
        S_BRD: state_q <= S_BCHK;
        S_BCHK: begin
          if (tm_rd && om_rd == o_q) begin
            pord_q  <= om_rd;
            state_q <= S_UNRD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_UNRD: begin
          n_q <= '1;
          p_q <= '1;
          state_q <= S_UNLNK;
        end
        S_UNLNK: begin
          if (n_q == '1) begin
            n_q <= rd_nil ? Nil : nm_rd;
            p_q <= pm_rd[LW-1] ? Nil : pm_rd;
          end else begin
            if (!pvalid) begin
              head_q[(pord_q > OrdW'(MAX_ORDER)) ? OrdW'(MAX_ORDER) : pord_q] <= n_q;
            end
            state_q <= S_UNLNK2;
          end
        end
        S_UNLNK2: begin
          g_q <= g_q & ~gstep(o_q);
          o_q <= o_q + OrdW'(1);
          if (o_q + OrdW'(1) < eff) begin
            b_q <= (g_q & ~gstep(o_q)) ^ gstep(o_q + OrdW'(1));
            state_q <= S_BRD;
          end else begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: state_q <= S_PUSH2;
        S_PUSH2: begin
          head_q[lidx] <= LW'(g_q);
          if (resume_q) begin
            resume_q <= 1'b0;
            o_q      <= k_q;
            state_q  <= S_SCAN;
          end else begin
            res_st_q <= StOk; state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rvalid_q) begin
            rvalid_q <= 1'b1;
          end else if (res.ready) begin
            rvalid_q <= 1'b0;
            ready_q  <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  `BBA_ASSERT(a_ready_idle, clk_i, rst_ni,
    req.ready |-> (state_q == S_IDLE), "ready outside idle")
  `BBA_ASSERT(a_one_result, clk_i, rst_ni,
    (res.valid && res.ready) |=> !res.valid, "result repeated")
  `BBA_ASSERT(a_res_hold, clk_i, rst_ni,
    (res.valid && !res.ready) |=> res.valid && $stable(res.payload), "result dropped")
  `BBA_ASSERT(a_busy, clk_i, rst_ni,
    (req.valid && req.ready) |=> !req.ready, "ready during work")
endmodule
